// ===== rtl/core/bounded_double_ended_queue_unit_assert.svh =====
// assertion macros for the bounded double-ended queue unit
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define BDEQ_ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define BDEQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define BDEQ_ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`define BDEQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/core/bdeq_pkg.sv =====
// shared constants, types and helpers of the double-ended queue
// no dependencies
`timescale 1ns / 1ps

package bdeq_pkg;

    localparam int DEPTH     = 16;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int CMD_W     = 3;
    localparam int WORD_W    = 32;
    // width wide enough for both the capacity register and the count
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef logic [PTR_W-1:0]         t_ptr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [CAP_W-1:0]         t_cap;
    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_cap  CAP_RESET  = 5'd16;
    localparam t_word EMPTY_WORD = '1;

    // command codes
    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_BACK   = 3'd3;
    localparam t_cmd CMD_PEEK       = 3'd4;

    // memory request from the pointer logic
    typedef struct packed {
        logic  we;
        t_ptr  waddr;
        t_word wdata;
        logic  re;
        t_ptr  raddr_front;
        t_ptr  raddr_rear;
    } t_mem_req;

    // status of the last command
    typedef struct packed {
        logic ok;
        t_cnt count;
        logic full;
    } t_stat;

    // fold a sum below twice the depth back into the ring
    function automatic t_ptr ptr_wrap(input logic [PTR_W:0] sum);
        logic [PTR_W:0] red;
        red = (sum >= (PTR_W+1)'(DEPTH)) ? sum - (PTR_W+1)'(DEPTH) : sum;
        return red[PTR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/bdeq_in_if.sv =====
// command channel of the double-ended queue: valid, ready, command and value
// depends on bdeq_pkg
`timescale 1ns / 1ps

interface bdeq_in_if;
    import bdeq_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  command;
    t_word value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== rtl/core/bdeq_out_if.sv =====
// result channel of the double-ended queue: valid, ready and result fields
// depends on bdeq_pkg
`timescale 1ns / 1ps

interface bdeq_out_if;
    import bdeq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 ok;
    t_word                front_value;
    t_word                rear_value;
    logic                 empty_res;
    logic                 full_res;
    logic [CNT_OUT_W-1:0] count;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output empty_res, output full_res, output count, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input empty_res, input full_res, input count, output ready);
endinterface

// ===== rtl/core/bounded_double_ended_queue_unit.sv =====
// top level of the bounded double-ended queue: handshake and result register
// depends on bdeq_pkg, bdeq_in_if, bdeq_out_if, bdeq_ctrl, bdeq_ram and the assert header
//
//   channel    | role   | transfer when | payload
//   -----------+--------+---------------+----------------------------------------------
//   i_cmd_ch   | sink   | valid & ready | command, value
//   o_res_ch   | source | valid & ready | ok, front_value, rear_value, empty_res,
//              |        |               | full_res, count
//   i_cfg_we   | write  | i_cfg_we high | capacity (i_cfg_wdata)
//
// The accept cycle updates the pointers, writes the ring and issues both reads;
// once the output register is free, the read stage then takes the registered read
// data into the result register. A new command waits while one is still pending.
// A result waiting in the output register does not block the next command; the
// read stage holds while the output register is full. Synchronous reset, no clearing.
`timescale 1ns / 1ps
`include "bounded_double_ended_queue_unit_assert.svh"

module bounded_double_ended_queue_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  bdeq_pkg::t_cap i_cfg_wdata,
    bdeq_in_if.sink        i_cmd_ch,
    bdeq_out_if.source     o_res_ch
);
    import bdeq_pkg::*;

    t_mem_req mem_req;
    t_stat    stat;
    t_word    rd_front;
    t_word    rd_rear;
    logic     accept;
    logic     out_free;
    logic     load_out;
    logic     stat_empty;

    logic                 r_pend;
    logic                 r_out_valid;
    logic                 r_ok;
    t_word                r_front;
    t_word                r_rear;
    logic                 r_empty;
    logic                 r_full;
    logic [CNT_OUT_W-1:0] r_count;

    // handshake
    assign i_cmd_ch.ready = !r_pend;
    assign accept         = i_cmd_ch.valid && !r_pend;
    assign out_free       = !r_out_valid || o_res_ch.ready;
    assign load_out       = r_pend && out_free;
    assign stat_empty     = (stat.count == '0);

    bdeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_command   (i_cmd_ch.command),
        .i_value     (i_cmd_ch.value),
        .o_req       (mem_req),
        .o_stat      (stat)
    );

    bdeq_ram u_ram (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd_front (rd_front),
        .o_rd_rear  (rd_rear)
    );

    // read stage and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pend <= 1'b1;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ok    <= stat.ok;
            r_front <= stat_empty ? EMPTY_WORD : rd_front;
            r_rear  <= stat_empty ? EMPTY_WORD : rd_rear;
            r_empty <= stat_empty;
            r_full  <= stat.full;
            r_count <= CNT_OUT_W'(stat.count);
        end
    end

    assign o_res_ch.valid       = r_out_valid;
    assign o_res_ch.ok          = r_ok;
    assign o_res_ch.front_value = r_front;
    assign o_res_ch.rear_value  = r_rear;
    assign o_res_ch.empty_res   = r_empty;
    assign o_res_ch.full_res    = r_full;
    assign o_res_ch.count       = r_count;

    // checks
    `BDEQ_ASSERT_NEXT(a_accept_pends, i_clk, i_rst_n, accept, r_pend, "accepted command not pending")
    `BDEQ_ASSERT_NEXT(a_pend_drains, i_clk, i_rst_n, load_out, !r_pend && r_out_valid, "read stage did not move to output")
    `BDEQ_ASSERT_IMPLIES(a_empty_words, i_clk, i_rst_n, o_res_ch.valid && o_res_ch.empty_res, o_res_ch.front_value == EMPTY_WORD && o_res_ch.rear_value == EMPTY_WORD, "empty result with live words")
endmodule

// ===== rtl/core/bdeq_ram.sv =====
// ring storage: one write port, two registered read ports, write-first bypass
// depends on bdeq_pkg
`timescale 1ns / 1ps

module bdeq_ram (
    input  logic              i_clk,
    input  bdeq_pkg::t_mem_req i_req,
    output bdeq_pkg::t_word    o_rd_front,
    output bdeq_pkg::t_word    o_rd_rear
);
    import bdeq_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_front;
    t_word r_rd_rear;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // reads, new data forwarded when the same entry is written this cycle
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_front <= (i_req.we && i_req.waddr == i_req.raddr_front)
                          ? i_req.wdata : r_mem[i_req.raddr_front];
            r_rd_rear  <= (i_req.we && i_req.waddr == i_req.raddr_rear)
                          ? i_req.wdata : r_mem[i_req.raddr_rear];
        end
    end

    assign o_rd_front = r_rd_front;
    assign o_rd_rear  = r_rd_rear;
endmodule

// ===== rtl/core/bdeq_ctrl.sv =====
// head pointer, entry count and capacity register; issues ring accesses
// depends on bdeq_pkg
`timescale 1ns / 1ps

module bdeq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  bdeq_pkg::t_cap     i_cfg_wdata,
    input  logic               i_accept,
    input  bdeq_pkg::t_cmd     i_command,
    input  bdeq_pkg::t_word    i_value,
    output bdeq_pkg::t_mem_req o_req,
    output bdeq_pkg::t_stat    o_stat
);
    import bdeq_pkg::*;

    t_ptr r_head;
    t_ptr n_head;
    t_cnt r_count;
    t_cnt n_count;
    t_cap r_cap;
    logic r_ok;
    logic n_ok;

    logic [CMP_W-1:0] cap_x;
    logic [CMP_W-1:0] eff_cap;
    logic             full_now;
    logic             empty_now;
    logic [PTR_W:0]   head_x;

    // effective capacity: register clipped to the ring depth
    assign cap_x     = CMP_W'(r_cap);
    assign eff_cap   = (cap_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_x;
    assign full_now  = CMP_W'(r_count) >= eff_cap;
    assign empty_now = (r_count == '0);
    assign head_x    = (PTR_W+1)'(r_head);

    // command decode and pointer update
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_ok        = 1'b1;
        o_req.we    = 1'b0;
        o_req.waddr = r_head;
        o_req.wdata = i_value;
        unique case (i_command)
            CMD_PUSH_FRONT: begin
                if (full_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_head      = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - 1'b1;
                    n_count     = r_count + 1'b1;
                    o_req.we    = i_accept;
                    o_req.waddr = n_head;
                end
            end
            CMD_PUSH_BACK: begin
                if (full_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_count     = r_count + 1'b1;
                    o_req.we    = i_accept;
                    o_req.waddr = ptr_wrap(head_x + (PTR_W+1)'(r_count));
                end
            end
            CMD_POP_FRONT: begin
                if (empty_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = ptr_wrap(head_x + (PTR_W+1)'(1));
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                // peek and unused codes leave the queue alone
            end
        endcase

        // read the new front and rear entries
        o_req.re          = i_accept;
        o_req.raddr_front = n_head;
        o_req.raddr_rear  = ptr_wrap((PTR_W+1)'(n_head) + (PTR_W+1)'(n_count - 1'b1));
    end

    // queue state and capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_ok    <= 1'b0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_accept) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_ok    <= n_ok;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    assign o_stat.ok    = r_ok;
    assign o_stat.count = r_count;
    assign o_stat.full  = full_now;
endmodule

// ===== tb/bdeq_checker.sv =====
// result checker of the double-ended queue: predicts every result and compares it
// depends on bdeq_pkg, bdeq_in_if and bdeq_out_if
`timescale 1ns / 1ps

module bdeq_checker
    import bdeq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  t_cap i_cfg_wdata,
    bdeq_in_if   cmd_ch,
    bdeq_out_if  res_ch,
    output int   o_pending,
    output int   o_checked,
    output int   o_fail_cnt
);

    typedef struct packed {
        logic                 ok;
        t_word                front_value;
        t_word                rear_value;
        logic                 empty_res;
        logic                 full_res;
        logic [CNT_OUT_W-1:0] count;
    } t_res;

    // shadow copy of the queue
    t_word ring [DEPTH];
    t_ptr  head;
    int    held;
    t_cap  capacity;

    t_res  expected_q [$];
    t_res  got;
    t_res  want;
    int    checked;
    int    fails;

    // apply one command to the shadow queue and return the result it gives
    function automatic t_res apply_cmd(input t_cmd c, input t_word v);
        t_res r;
        int   lim;
        lim  = (capacity > DEPTH) ? DEPTH : capacity;
        r.ok = 1'b1;
        case (c)
            CMD_PUSH_FRONT: begin
                if (held >= lim) begin
                    r.ok = 1'b0;
                end else begin
                    head = head - t_ptr'(1);
                    ring[head] = v;
                    held++;
                end
            end
            CMD_PUSH_BACK: begin
                if (held >= lim) begin
                    r.ok = 1'b0;
                end else begin
                    ring[t_ptr'(head + held)] = v;
                    held++;
                end
            end
            CMD_POP_FRONT: begin
                if (held == 0) begin
                    r.ok = 1'b0;
                end else begin
                    head = head + t_ptr'(1);
                    held--;
                end
            end
            CMD_POP_BACK: begin
                if (held == 0) r.ok = 1'b0;
                else           held--;
            end
            // peek and the unused codes leave the queue alone
            default: ;
        endcase
        if (held == 0) begin
            r.front_value = EMPTY_WORD;
            r.rear_value  = EMPTY_WORD;
        end else begin
            r.front_value = ring[head];
            r.rear_value  = ring[t_ptr'(head + held - 1)];
        end
        r.empty_res = (held == 0);
        r.full_res  = (held >= lim);
        r.count     = held[CNT_OUT_W-1:0];
        return r;
    endfunction

    // watch both channels; results are matched before the new command is queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head     = '0;
            held     = 0;
            capacity = CAP_RESET;
            checked  = 0;
            fails    = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_wdata;

            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.ok, res_ch.front_value, res_ch.rear_value,
                        res_ch.empty_res, res_ch.full_res, res_ch.count};
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] result transfer with none outstanding", $realtime);
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (got.ok !== want.ok || got.front_value !== want.front_value ||
                        got.rear_value !== want.rear_value ||
                        got.empty_res !== want.empty_res ||
                        got.full_res !== want.full_res || got.count !== want.count) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] mismatch on result %0d", $realtime, checked);
                            $display("  expected ok=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                                     want.ok, want.front_value, want.rear_value,
                                     want.empty_res, want.full_res, want.count);
                            $display("  actual   ok=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                                     got.ok, got.front_value, got.rear_value,
                                     got.empty_res, got.full_res, got.count);
                        end
                    end
                end
            end

            if (cmd_ch.valid && cmd_ch.ready)
                expected_q.push_back(apply_cmd(cmd_ch.command, cmd_ch.value));
        end
        o_pending  <= expected_q.size();
        o_checked  <= checked;
        o_fail_cnt <= fails;
    end

endmodule

// ===== tb/bounded_double_ended_queue_unit_tb.sv =====
// testbench top of the double-ended queue: clock, reset, stimulus and verdict
// depends on bdeq_pkg, bdeq_in_if, bdeq_out_if, bdeq_checker and the unit itself
`timescale 1ns / 1ps

module bounded_double_ended_queue_unit_tb;
    import bdeq_pkg::*;

    localparam int   LIMIT         = 200000;
    localparam int   PHASES        = 10;
    localparam int   PHASE_ITEMS   = 200;
    localparam t_cmd CMD_UNUSED_LO = CMD_PEEK + t_cmd'(1);
    localparam t_cmd CMD_UNUSED_HI = '1;
    localparam t_word WORD_MAX     = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN     = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_cap i_cfg_wdata;
    bit   idle_on;
    int   n_items;
    int   n_cap_writes;
    int   pending;
    int   checked;
    int   fail_cnt;
    int   cycle_cnt;

    bdeq_in_if  cmd_ch ();
    bdeq_out_if res_ch ();

    bounded_double_ended_queue_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd_ch   (cmd_ch),
        .o_res_ch   (res_ch)
    );

    bdeq_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .cmd_ch     (cmd_ch),
        .res_ch     (res_ch),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_fail_cnt (fail_cnt)
    );

    always #2 i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 18) : 1'b1;
    end

    // hard stop on a hang
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("run stopped after %0d cycles, %0d results outstanding", LIMIT, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // one command transfer, with random gaps ahead of it
    task automatic send_cmd(input t_cmd c, input t_word v);
        while (idle_on && $urandom_range(0, 99) < 18) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.value   <= v;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        n_items++;
    endtask

    // wait until every result is back and the pipeline is quiet
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input t_cap c);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_cap_writes++;
    endtask

    // words weighted towards the extremes
    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return EMPTY_WORD;
            4:       return t_word'($urandom_range(0, 15));
            default: return t_word'($urandom);
        endcase
    endfunction

    // push share in percent steers the fill level of the queue
    function automatic t_cmd pick_cmd(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (r < 95)
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else
            return t_cmd'($urandom_range(CMD_PEEK, CMD_UNUSED_HI));
    endfunction

    initial begin
        t_cap cap_plan [PHASES];
        int   push_plan [PHASES];

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_PEEK;
        cmd_ch.value   = '0;
        res_ch.ready   = 1'b0;
        idle_on        = 1'b1;
        n_items        = 0;
        n_cap_writes   = 0;

        // fill at the widest setting, then shrink below the count held
        cap_plan  = '{5'd31, 5'd16, 5'd2, 5'd0, 5'd1, 5'd8, 5'd17, 5'd4,
                      t_cap'($urandom_range(0, 31)), 5'd15};
        push_plan = '{85, 50, 30, 60, 50, 70, 90, 20, 50, 40};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue at the reset capacity
        send_cmd(CMD_POP_FRONT, WORD_MAX);
        send_cmd(CMD_POP_BACK, WORD_MIN);
        send_cmd(CMD_PEEK, '0);
        send_cmd(CMD_UNUSED_HI, EMPTY_WORD);

        // extreme words at both ends, including a stored all-ones word
        send_cmd(CMD_PUSH_FRONT, WORD_MAX);
        send_cmd(CMD_PUSH_BACK, WORD_MIN);
        send_cmd(CMD_PUSH_FRONT, '0);
        send_cmd(CMD_PUSH_BACK, EMPTY_WORD);
        send_cmd(CMD_PEEK, WORD_MAX);
        send_cmd(CMD_UNUSED_LO, WORD_MIN);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_FRONT, '0);

        // single-entry queue
        write_capacity(5'd1);
        send_cmd(CMD_PUSH_BACK, pick_word());
        send_cmd(CMD_PUSH_FRONT, pick_word());
        send_cmd(CMD_PUSH_BACK, pick_word());
        send_cmd(CMD_POP_BACK, '0);

        // zero capacity refuses every push and reads as full
        write_capacity(5'd0);
        send_cmd(CMD_PUSH_FRONT, pick_word());
        send_cmd(CMD_PUSH_BACK, pick_word());
        send_cmd(CMD_PEEK, '0);

        // random phases, the queue contents carry over between them
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(cap_plan[p]);
            idle_on = (p != 5);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_cmd(pick_cmd(push_plan[p]), pick_word());
        end
        idle_on = 1'b1;

        drain();
        repeat (8) @(posedge i_clk);

        $display("%0d commands over %0d capacity writes (0, 1, 16, above the ring size and lowered below the fill level)",
                 n_items, n_cap_writes);
        $display("%0d results checked, %0d mismatches", checked, fail_cnt);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
